// File: hdl/ccp_pkg.sv
// ============================================================================
// ccp_pkg: shared constants for the circumcircle block
// Result widths, divider and square root sizes, and the queue depth.
// ============================================================================
package ccp_pkg;

    // Width of each result coordinate and of the radius.
    localparam int OUT_W      = 32;
    // Width of the configuration register.
    localparam int LIMIT_W    = 16;
    // Quotient bits produced by the center divider.
    localparam int QUO_W      = 32;
    // Distance from the second point to the center, signed.
    localparam int DX_W       = 33;
    // Squared distance, unsigned.
    localparam int DIST_W     = 2 * DX_W + 1;
    // Root bits and the working width of the square root remainder.
    localparam int ROOT_W     = 34;
    localparam int SQR_W      = DIST_W + 1;
    // Entries in the queue between the front and the back end.
    localparam int FIFO_DEPTH = 4;

    // Width of one queue entry for a given coordinate width:
    // two numerators, the determinant, the second point and the flag.
    function automatic int entry_w(input int w);
        return 2 * (3 * w + 3) + (2 * w + 3) + 2 * w + 1;
    endfunction

endpackage

// File: hdl/ccp_ifs.sv
// ============================================================================
// ccp_ifs: channel interfaces of the circumcircle block
// Point input channel, result output channel and configuration write channel.
// ============================================================================
interface ccp_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic signed [W-1:0] second_x;
    logic signed [W-1:0] second_y;
    logic signed [W-1:0] third_x;
    logic signed [W-1:0] third_y;
    modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                    input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                    output ready);
endinterface

interface ccp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ccp_pkg::OUT_W-1:0]   center_x;
    logic signed [ccp_pkg::OUT_W-1:0]   center_y;
    logic        [ccp_pkg::OUT_W-1:0]   circle_radius;
    logic                               degenerate;
    logic                               saturated;
    modport source (output valid, center_x, center_y, circle_radius, degenerate, saturated,
                    input ready);
    modport sink   (input valid, center_x, center_y, circle_radius, degenerate, saturated,
                    output ready);
endinterface

interface ccp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ccp_pkg::LIMIT_W-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/ccp_fifo.sv
// ============================================================================
// ccp_fifo: short queue between the front and the back end
// Register based first-in first-out buffer with valid/ready on both sides.
// ============================================================================
module ccp_fifo #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);
    import ccp_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    logic [DW-1:0] r_mem [0:FIFO_DEPTH-1];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != (AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hdl/ccp_front.sv
// ============================================================================
// ccp_front: front end of the circumcircle block
// Accepts point triples, forms the determinant and the two center
// numerators, and classifies each triple as degenerate or not.
// ============================================================================
module ccp_front #(
    parameter int W = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ccp_in_if.sink                            i_in,
    input  logic [ccp_pkg::LIMIT_W-1:0]       i_limit,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ccp_pkg::entry_w(W)-1:0]    o_entry
);
    import ccp_pkg::*;

    localparam int DW   = W + 1;
    localparam int SQW  = 2 * W;
    localparam int DSW  = 2 * W + 1;
    localparam int PW   = 2 * W + 2;
    localparam int DETW = 2 * W + 3;
    localparam int NPW  = 3 * W + 2;
    localparam int NUMW = 3 * W + 3;

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1: the accepted points.
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    // Stage 2: difference vectors and squared norms.
    logic signed [DW-1:0] r2_ax, r2_ay, r2_bx, r2_by;
    logic        [SQW-1:0] r2_s1, r2_s2, r2_s3;
    logic signed [W-1:0]  r2_x2, r2_y2;
    // Stage 3: norm differences and determinant.
    logic signed [DW-1:0]   r3_ax, r3_ay, r3_bx, r3_by;
    logic signed [DSW-1:0]  r3_d12, r3_d23;
    logic signed [DETW-1:0] r3_det;
    logic signed [W-1:0]    r3_x2, r3_y2;
    // Stage 4: numerator products.
    logic signed [NPW-1:0]  r4_p1, r4_p2, r4_p3, r4_p4;
    logic signed [DETW-1:0] r4_det;
    logic signed [W-1:0]    r4_x2, r4_y2;

    logic signed [SQW-1:0]  w_qx1, w_qy1, w_qx2, w_qy2, w_qx3, w_qy3;
    logic signed [PW-1:0]   w_pa, w_pb;
    logic signed [NUMW-1:0] w_numx, w_numy;
    logic        [DETW-1:0] w_mag;
    logic                   w_deg;

    // The whole front moves unless its last stage waits on a full queue.
    assign w_en       = !r_v4 || i_ready;
    assign i_in.ready = w_en;
    assign o_valid    = r_v4;

    // Squares of the coordinates.
    assign w_qx1 = r_x1 * r_x1;
    assign w_qy1 = r_y1 * r_y1;
    assign w_qx2 = r_x2 * r_x2;
    assign w_qy2 = r_y2 * r_y2;
    assign w_qx3 = r_x3 * r_x3;
    assign w_qy3 = r_y3 * r_y3;

    // Determinant products.
    assign w_pa = r2_ax * r2_by;
    assign w_pb = r2_bx * r2_ay;

    // Numerators, determinant magnitude and the collinear test.
    assign w_numx = NUMW'(r4_p1) - NUMW'(r4_p2);
    assign w_numy = NUMW'(r4_p3) - NUMW'(r4_p4);
    assign w_mag  = r4_det[DETW-1] ? $unsigned(-r4_det) : $unsigned(r4_det);
    assign w_deg  = (w_mag <= DETW'(i_limit));

    assign o_entry = {w_numx, w_numy, r4_det, r4_x2, r4_y2, w_deg};

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1   <= i_in.first_x;
            r_y1   <= i_in.first_y;
            r_x2   <= i_in.second_x;
            r_y2   <= i_in.second_y;
            r_x3   <= i_in.third_x;
            r_y3   <= i_in.third_y;

            r2_ax  <= DW'(r_x1) - DW'(r_x2);
            r2_ay  <= DW'(r_y1) - DW'(r_y2);
            r2_bx  <= DW'(r_x2) - DW'(r_x3);
            r2_by  <= DW'(r_y2) - DW'(r_y3);
            r2_s1  <= $unsigned(w_qx1) + $unsigned(w_qy1);
            r2_s2  <= $unsigned(w_qx2) + $unsigned(w_qy2);
            r2_s3  <= $unsigned(w_qx3) + $unsigned(w_qy3);
            r2_x2  <= r_x2;
            r2_y2  <= r_y2;

            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
            r3_d12 <= $signed({1'b0, r2_s1}) - $signed({1'b0, r2_s2});
            r3_d23 <= $signed({1'b0, r2_s2}) - $signed({1'b0, r2_s3});
            r3_det <= DETW'(w_pa) - DETW'(w_pb);
            r3_x2  <= r2_x2;
            r3_y2  <= r2_y2;

            r4_p1  <= r3_d12 * r3_by;
            r4_p2  <= r3_d23 * r3_ay;
            r4_p3  <= r3_d23 * r3_ax;
            r4_p4  <= r3_d12 * r3_bx;
            r4_det <= r3_det;
            r4_x2  <= r3_x2;
            r4_y2  <= r3_y2;
        end
    end

endmodule

// File: hdl/ccp_back.sv
// ============================================================================
// ccp_back: back end of the circumcircle block
// Pipelined center division, clipping, squared distance, pipelined
// rounded square root and the output register.
// ============================================================================
module ccp_back #(
    parameter int W = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ccp_pkg::entry_w(W)-1:0]    i_entry,
    ccp_out_if.source                         o_out
);
    import ccp_pkg::*;

    localparam int DETW = 2 * W + 3;
    localparam int NUMW = 3 * W + 3;
    localparam int CW   = 3 * W + 38;

    typedef struct packed {
        logic                v;
        logic [CW-1:0]       rx;
        logic [CW-1:0]       ry;
        logic [CW-1:0]       d;
        logic [QUO_W-1:0]    qx;
        logic [QUO_W-1:0]    qy;
        logic                negx;
        logic                negy;
        logic                ovx;
        logic                ovy;
        logic                deg;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] y2;
    } t_div;

    typedef struct packed {
        logic                    v;
        logic [SQR_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic                    sat;
        logic                    deg;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
    } t_sqr;

    logic w_en;

    // Queue entry fields.
    logic signed [NUMW-1:0] w_numx, w_numy;
    logic signed [DETW-1:0] w_det;
    logic signed [W-1:0]    w_x2, w_y2;
    logic                   w_deg;

    t_div r_div [0:QUO_W];
    t_div n_div [0:QUO_W];
    t_sqr r_sq  [0:ROOT_W];
    t_sqr n_sq  [0:ROOT_W];

    // Clip stage and square stage.
    logic                     r_sv, r_ssat, r_sdeg;
    logic signed [DX_W-1:0]   r_sdx, r_sdy;
    logic signed [OUT_W-1:0]  r_scx, r_scy;
    logic                     r_mv, r_msat, r_mdeg;
    logic signed [2*DX_W-1:0] r_mdx2, r_mdy2;
    logic signed [OUT_W-1:0]  r_mcx, r_mcy;

    // Output register.
    logic                     r_ov;
    logic signed [OUT_W-1:0]  r_ocx, r_ocy;
    logic        [OUT_W-1:0]  r_orad;
    logic                     r_odeg, r_osat;

    logic                     w_satx, w_saty;
    logic signed [OUT_W-1:0]  w_cx, w_cy;
    logic        [ROOT_W:0]   w_rr;
    logic                     w_radsat;

    assign {w_numx, w_numy, w_det, w_x2, w_y2, w_deg} = i_entry;

    // The back pipeline moves whenever the output register can take a result.
    assign w_en    = !r_ov || o_out.ready;
    assign o_ready = w_en;

    // Center clipping for one coordinate: returns the output value and the clip flag.
    function automatic logic [OUT_W:0] clip_center(input logic [QUO_W-1:0] q,
                                                   input logic neg, input logic ov);
        logic [OUT_W:0] lim;
        logic [OUT_W:0] mag;
        logic           sat;
        logic [OUT_W:0] val;
        lim = neg ? ((OUT_W+1)'(1) << (OUT_W-1)) : (((OUT_W+1)'(1) << (OUT_W-1)) - 1'b1);
        sat = ov || ((OUT_W+1)'(q) > lim);
        mag = sat ? lim : (OUT_W+1)'(q);
        val = neg ? ((OUT_W+1)'(0) - mag) : mag;
        return {sat, val[OUT_W-1:0]};
    endfunction

    // Divider entry and the restoring steps, one quotient bit per stage.
    always_comb begin
        logic [NUMW-1:0] magx;
        logic [NUMW-1:0] magy;
        logic [DETW-1:0] magd;
        logic [CW-1:0]   nx;
        logic [CW-1:0]   ny;
        logic [CW-1:0]   lim;
        logic [CW-1:0]   tr;
        magx = w_numx[NUMW-1] ? $unsigned(-w_numx) : $unsigned(w_numx);
        magy = w_numy[NUMW-1] ? $unsigned(-w_numy) : $unsigned(w_numy);
        magd = w_det[DETW-1]  ? $unsigned(-w_det)  : $unsigned(w_det);
        nx   = CW'(magx) + CW'(magd);
        ny   = CW'(magy) + CW'(magd);
        lim  = CW'(magd) << (QUO_W + 1);
        n_div[0].v    = i_valid;
        n_div[0].rx   = nx;
        n_div[0].ry   = ny;
        n_div[0].d    = CW'(magd) << 1;
        n_div[0].qx   = '0;
        n_div[0].qy   = '0;
        n_div[0].negx = w_numx[NUMW-1] != w_det[DETW-1];
        n_div[0].negy = w_numy[NUMW-1] != w_det[DETW-1];
        n_div[0].ovx  = (nx >= lim);
        n_div[0].ovy  = (ny >= lim);
        n_div[0].deg  = w_deg;
        n_div[0].x2   = w_x2;
        n_div[0].y2   = w_y2;
        for (int k = 0; k < QUO_W; k++) begin
            n_div[k+1] = r_div[k];
            tr = r_div[k].d << (QUO_W - 1 - k);
            if (r_div[k].rx >= tr) begin
                n_div[k+1].rx = r_div[k].rx - tr;
                n_div[k+1].qx[QUO_W-1-k] = 1'b1;
            end
            if (r_div[k].ry >= tr) begin
                n_div[k+1].ry = r_div[k].ry - tr;
                n_div[k+1].qy[QUO_W-1-k] = 1'b1;
            end
        end
    end

    // Clipped center from the finished quotients.
    assign {w_satx, w_cx} = clip_center(r_div[QUO_W].qx, r_div[QUO_W].negx, r_div[QUO_W].ovx);
    assign {w_saty, w_cy} = clip_center(r_div[QUO_W].qy, r_div[QUO_W].negy, r_div[QUO_W].ovy);

    // Square root entry and the digit steps, one root bit per stage.
    always_comb begin
        logic [SQR_W-1:0] tr;
        n_sq[0].v    = r_mv;
        n_sq[0].rem  = SQR_W'($unsigned(r_mdx2)) + SQR_W'($unsigned(r_mdy2));
        n_sq[0].root = '0;
        n_sq[0].sat  = r_msat;
        n_sq[0].deg  = r_mdeg;
        n_sq[0].cx   = r_mcx;
        n_sq[0].cy   = r_mcy;
        for (int k = 0; k < ROOT_W; k++) begin
            n_sq[k+1] = r_sq[k];
            tr = (SQR_W'(r_sq[k].root) << (ROOT_W - k))
               + (SQR_W'(1) << (2 * (ROOT_W - 1 - k)));
            if (r_sq[k].rem >= tr) begin
                n_sq[k+1].rem = r_sq[k].rem - tr;
                n_sq[k+1].root[ROOT_W-1-k] = 1'b1;
            end
        end
    end

    // Round to nearest and clip the radius.
    assign w_rr = {1'b0, r_sq[ROOT_W].root}
                + {{ROOT_W{1'b0}}, (r_sq[ROOT_W].rem > SQR_W'(r_sq[ROOT_W].root))};
    assign w_radsat = (w_rr[ROOT_W:OUT_W] != '0);

    // Divider and square root stages; reset clears every valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_div[k].v <= 1'b0;
            end
            for (int k = 0; k <= ROOT_W; k++) begin
                r_sq[k].v <= 1'b0;
            end
            r_sv <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_div[k] <= n_div[k];
            end
            for (int k = 0; k <= ROOT_W; k++) begin
                r_sq[k] <= n_sq[k];
            end
            r_sv <= r_div[QUO_W].v;
            r_mv <= r_sv;
            r_ov <= r_sq[ROOT_W].v;
        end
    end

    // Clip, square and output datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scx  <= w_cx;
            r_scy  <= w_cy;
            r_sdx  <= DX_W'(r_div[QUO_W].x2) - DX_W'(w_cx);
            r_sdy  <= DX_W'(r_div[QUO_W].y2) - DX_W'(w_cy);
            r_ssat <= w_satx || w_saty;
            r_sdeg <= r_div[QUO_W].deg;

            r_mdx2 <= r_sdx * r_sdx;
            r_mdy2 <= r_sdy * r_sdy;
            r_mcx  <= r_scx;
            r_mcy  <= r_scy;
            r_msat <= r_ssat;
            r_mdeg <= r_sdeg;

            // Collinear triples give zeros and only the flag.
            if (r_sq[ROOT_W].deg) begin
                r_ocx  <= '0;
                r_ocy  <= '0;
                r_orad <= '0;
                r_odeg <= 1'b1;
                r_osat <= 1'b0;
            end else begin
                r_ocx  <= r_sq[ROOT_W].cx;
                r_ocy  <= r_sq[ROOT_W].cy;
                r_orad <= w_radsat ? '1 : w_rr[OUT_W-1:0];
                r_odeg <= 1'b0;
                r_osat <= r_sq[ROOT_W].sat || w_radsat;
            end
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.center_x      = r_ocx;
    assign o_out.center_y      = r_ocy;
    assign o_out.circle_radius = r_orad;
    assign o_out.degenerate    = r_odeg;
    assign o_out.saturated     = r_osat;

endmodule

// File: hdl/circumcircle_from_three_points.sv
// ============================================================================
// circumcircle_from_three_points: circle through three points
// Center and radius of the circle through three fixed point points, with a
// configurable collinear limit on the determinant.
// ============================================================================
//
//  Channel   Dir  Handshake      Payload
//  i_in      in   valid/ready    first_x/y, second_x/y, third_x/y
//  o_out     out  valid/ready    center_x/y, circle_radius, degenerate, saturated
//  i_cfg     in   valid/ready    data (collinear_limit)
//
//  One triple is accepted per cycle unless the front waits on a full queue.
//  The path holds four front stages, the queue, a 32 stage restoring divider
//  and a 34 stage square root. Reset clears the pipeline valid bits, the queue
//  and the limit register. An output stall freezes the back end; the four entry
//  queue lets the front keep accepting until it fills.
//
module circumcircle_from_three_points #(
    parameter int COORD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccp_in_if.sink      i_in,
    ccp_out_if.source   o_out,
    ccp_cfg_if.sink     i_cfg
);
    import ccp_pkg::*;

    localparam int EW = entry_w(COORD_WIDTH);

    logic [LIMIT_W-1:0] r_limit;
    logic               w_f_valid;
    logic               w_f_ready;
    logic [EW-1:0]      w_f_entry;
    logic               w_q_valid;
    logic               w_q_ready;
    logic [EW-1:0]      w_q_entry;

    // Configuration register, written on a transfer.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_limit <= i_cfg.data;
        end
    end

    // Front end: determinant, numerators and classification.
    ccp_front #(.W(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_limit (r_limit),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_entry (w_f_entry)
    );

    // Queue between the two ends.
    ccp_fifo #(.DW(EW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_entry),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_entry)
    );

    // Back end: division, clipping and radius.
    ccp_back #(.W(COORD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_entry (w_q_entry),
        .o_out   (o_out)
    );

    // The front holds its entry while the queue is full.
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_f_valid && !w_f_ready) |=> (w_f_valid && $stable(w_f_entry)))
        else $error("front entry changed while the queue was full");

    // The queue keeps offering an entry the back end did not take.
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && !w_q_ready) |=> w_q_valid)
        else $error("queue dropped an entry during a back end stall");

    // A degenerate result carries only the flag.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
        (o_out.center_x == 0 && o_out.center_y == 0 && o_out.circle_radius == 0 &&
         !o_out.saturated))
        else $error("degenerate result with nonzero fields");

endmodule

// File: tb/sv/tb_circumcircle_from_three_points.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_circumcircle_from_three_points: testbench of the circumcircle block
// Point triples go in over a valid/ready channel. A predictor computes each
// circle with exact wide integer math, and every result transfer is checked
// against the oldest prediction. The collinear limit is swept between phases.
// ============================================================================
module tb_circumcircle_from_three_points;
    import ccp_pkg::*;

    localparam int CW = 16;
    localparam int LAT = 120;
    localparam int LONG_HOLD = 600;
    localparam longint MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [31:0]        rad;
        logic               degen;
        logic               sat;
    } t_circle;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ccp_in_if #(.W(CW)) in_ch ();
    ccp_out_if          out_ch ();
    ccp_cfg_if          cfg_ch ();

    circumcircle_from_three_points #(.COORD_WIDTH(CW)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Clock generation.
    always #5 i_clk = ~i_clk;

    logic [15:0] limit_q;
    t_circle     circle_q[$];
    int          mismatches;
    longint      cycles;
    bit          idle_on;
    bit          hold_req;
    bit          hold_taken;
    int          hold_cycles;

    // Round num/(2*det) to nearest, ties away from zero, clip to 32 bits.
    function automatic logic signed [63:0] center_of(input logic signed [127:0] num,
                                                      input logic signed [127:0] det,
                                                      inout logic sat);
        logic [127:0] mn, md, q;
        logic         neg;
        logic [63:0]  lim;
        neg = num[127] ^ det[127];
        mn  = num[127] ? -num : num;
        md  = det[127] ? -det : det;
        q   = (mn + md) / (md << 1);
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q > {64'd0, lim}) begin
            sat = 1'b1;
            q = {64'd0, lim};
        end
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // Integer square root rounded to nearest.
    function automatic logic [63:0] root_of(input logic [127:0] v);
        logic [127:0] lo, hi, mid;
        lo = 0;
        hi = 128'h1_0000_0000_0000_0000;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        if (v - lo * lo > lo) lo = lo + 1;
        return lo[63:0];
    endfunction

    function automatic t_circle predict_circle(input logic signed [CW-1:0] p[6]);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, ax, ay, bx, by;
        logic signed [127:0] d12, d23, det, mag;
        logic signed [63:0]  cx, cy;
        logic signed [127:0] dx, dy;
        logic [63:0]         r;
        t_circle             c;
        logic                sat;
        x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3]; x3 = p[4]; y3 = p[5];
        ax = x1 - x2; ay = y1 - y2; bx = x2 - x3; by = y2 - y3;
        d12 = (x1 * x1 + y1 * y1) - (x2 * x2 + y2 * y2);
        d23 = (x2 * x2 + y2 * y2) - (x3 * x3 + y3 * y3);
        det = ax * by - bx * ay;
        mag = det < 0 ? -det : det;
        c = '0;
        if (mag <= limit_q) begin
            c.degen = 1'b1;
            return c;
        end
        sat = 1'b0;
        cx = center_of(d12 * by - d23 * ay, det, sat);
        cy = center_of(d23 * ax - d12 * bx, det, sat);
        dx = x2 - cx;
        dy = y2 - cy;
        r = root_of(dx * dx + dy * dy);
        if (r > 64'hffff_ffff) begin
            r = 64'hffff_ffff;
            sat = 1'b1;
        end
        c.cx = cx[31:0]; c.cy = cy[31:0]; c.rad = r[31:0]; c.sat = sat;
        return c;
    endfunction

    // Send one triple and record its predicted circle on acceptance.
    // Valid stays high after a transfer so triples can follow back to back.
    task automatic send_triple(input logic signed [CW-1:0] p[6]);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.first_x  <= p[0]; in_ch.first_y  <= p[1];
        in_ch.second_x <= p[2]; in_ch.second_y <= p[3];
        in_ch.third_x  <= p[4]; in_ch.third_y  <= p[5];
        do @(posedge i_clk); while (!in_ch.ready);
        circle_q.push_back(predict_circle(p));
    endtask

    task automatic send_points(input int a, b, c, d, e, f);
        logic signed [CW-1:0] p[6];
        p[0] = CW'(a); p[1] = CW'(b); p[2] = CW'(c);
        p[3] = CW'(d); p[4] = CW'(e); p[5] = CW'(f);
        send_triple(p);
    endtask

    // Stop offering, wait for all predicted circles, then let the pipeline drain.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (circle_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_q = v;
    endtask

    task automatic test_directed();
        send_points(0, 0, 256, 0, 0, 256);
        send_points(0, 0, 0, 0, 0, 0);
        send_points(0, 0, 256, 256, 512, 512);
        send_points(-32768, -32768, 32767, -32768, -32768, 32767);
        send_points(32767, 32767, -32768, 32767, 32767, -32768);
        send_points(0, 0, 1, 0, 0, 1);
        send_points(0, 0, 1, 0, 2, 1);
        send_points(0, 0, 32767, 1, -32768, 0);
        send_points(-32768, 0, 32767, 0, 0, 1);
        send_points(100, -200, 300, 400, -500, 600);
        send_points(1, 1, 1, 1, 5, 9);
        send_points(256, 0, -256, 0, 0, 256);
        send_points(-1, -1, -1, 0, 0, -1);
        send_points(3, 0, 0, 3, 1, 1);
        send_points(-32768, -32768, -32768, -32768, 32767, 32767);
    endtask

    // Random triples: mostly full range, some small and near collinear.
    task automatic test_random(input int n);
        logic signed [CW-1:0] p[6];
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 3);
            for (int j = 0; j < 6; j++) begin
                case (k)
                    0: begin
                        p[j] = $signed(CW'($urandom_range(0, 15)) - CW'(8));
                    end
                    default: begin
                        p[j] = CW'($urandom);
                    end
                endcase
            end
            if (k == 1) begin
                // Nearly collinear: third point close to the line extension.
                p[4] = p[2] + (p[2] - p[0]) + CW'($urandom_range(0, 3));
                p[5] = p[3] + (p[3] - p[1]);
            end
            send_triple(p);
        end
    endtask

    // Check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_circle got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.center_x, out_ch.center_y, out_ch.circle_radius,
                   out_ch.degenerate, out_ch.saturated};
            if (circle_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = circle_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected cx=%0d cy=%0d r=%0d d=%b s=%b",
                                 want.cx, want.cy, want.rad, want.degen, want.sat);
                        $display("          actual   cx=%0d cy=%0d r=%0d d=%b s=%b",
                                 got.cx, got.cy, got.rad, got.degen, got.sat);
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts and one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= 0;
            hold_taken   <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= LONG_HOLD;
            hold_taken   <= 1'b1;
        end else if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= $urandom_range(0, 16);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.first_x = '0; in_ch.first_y = '0;
        in_ch.second_x = '0; in_ch.second_y = '0;
        in_ch.third_x = '0; in_ch.third_y = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        limit_q = '0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        drain();
        write_limit(16'hffff);
        test_directed();
        test_random(250);
        drain();
        write_limit(16'd300);
        test_random(250);
        drain();
        // Long output hold-off while the sender keeps offering triples.
        hold_req = 1'b1;
        test_random(150);
        drain();
        write_limit(16'd0);
        test_random(370);
        idle_on = 1'b0;
        test_random(300);
        drain();

        if (mismatches == 0 && circle_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
